FILE: src/cnl_pkg.sv
package cnl_pkg;

    // Input and result field widths
    localparam int CARD_W  = 54;
    localparam int CNT_W   = 5;
    localparam int BRAND_W = 2;

    // Longest number that can be reported as valid
    localparam int MAX_DIGITS = 16;

    // Decimal digits needed to hold any 54-bit value
    localparam int DIGITS_N = 17;
    localparam int BCD_W    = 4 * DIGITS_N;

    // Binary-to-decimal conversion: one shift-and-adjust step per bit
    localparam int STEPS_PER_STAGE = 6;
    localparam int CONV_STAGES     = CARD_W / STEPS_PER_STAGE;

    // Luhn sum split into group sums, then added in the last stage
    localparam int GROUP_SZ = 5;
    localparam int GROUPS_N = (DIGITS_N + GROUP_SZ - 1) / GROUP_SZ;
    localparam int PSUM_W   = $clog2(9 * GROUP_SZ + 1);
    localparam int SUM_MAX  = 9 * DIGITS_N;
    localparam int SUM_W    = $clog2(SUM_MAX + 1);

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS = 2'd1;
    localparam logic [CFG_W-1:0] MIN_DIGITS_RST = 5'd13;
    localparam logic [CFG_W-1:0] MAX_DIGITS_RST = 5'd16;

    typedef enum logic [BRAND_W-1:0] {
        BRAND_INVALID = 2'd0,
        BRAND_P3X     = 2'd1,   // prefix 34 or 37
        BRAND_P5X     = 2'd2,   // prefix 51 to 55
        BRAND_P4X     = 2'd3    // prefix 40 to 49
    } t_brand;

    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [CARD_W-1:0] bin;
    } t_conv;

    typedef struct packed {
        logic [CNT_W-1:0]                   count;
        t_brand                             pre_brand;
        logic [GROUPS_N-1:0][PSUM_W-1:0]    psum;
    } t_digit_info;

    // One shift-and-add-3 step over the whole decimal register
    function automatic t_conv dd_step(input t_conv s);
        t_conv r;
        r = s;
        for (int k = 0; k < DIGITS_N; k++) begin
            if (r.bcd[4*k +: 4] >= 4'd5) begin
                r.bcd[4*k +: 4] = r.bcd[4*k +: 4] + 4'd3;
            end
        end
        r = t_conv'({r.bcd, r.bin} << 1);
        return r;
    endfunction

    // Doubled digit folded back to one digit
    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [3:0] r;
        unique case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/cnl_bcd_stage.sv
module cnl_bcd_stage
    import cnl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_advance,
    input  logic  i_valid,
    input  t_conv i_data,
    output logic  o_valid,
    output t_conv o_data
);

    logic  r_valid;
    t_conv r_data;
    t_conv n_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            n_data = dd_step(n_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/cnl_digit_stage.sv
module cnl_digit_stage
    import cnl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_valid,
    input  logic [BCD_W-1:0] i_bcd,
    output logic             o_valid,
    output t_digit_info      o_info
);

    logic        r_valid;
    t_digit_info r_info;
    t_digit_info n_info;

    logic [CNT_W-1:0]                n_count;
    t_brand                          n_pre_brand;
    logic [GROUPS_N-1:0][PSUM_W-1:0] n_psum;

    logic [3:0]  digit [DIGITS_N];
    logic [3:0]  contrib [DIGITS_N];
    logic [3:0]  hi_digit;
    logic [3:0]  lo_digit;
    logic        two_digits;
    logic        found;

    always_comb begin
        for (int k = 0; k < DIGITS_N; k++) begin
            digit[k]   = i_bcd[4*k +: 4];
            // every second digit from the right is doubled
            contrib[k] = (k % 2 == 1) ? luhn_double(digit[k]) : digit[k];
        end
    end

    // Leading digit search, top down
    always_comb begin
        found        = 1'b0;
        n_count      = '0;
        hi_digit     = '0;
        lo_digit     = '0;
        two_digits   = 1'b0;
        for (int k = DIGITS_N - 1; k >= 1; k--) begin
            if (!found && digit[k] != 4'd0) begin
                found        = 1'b1;
                n_count      = CNT_W'(k + 1);
                hi_digit     = digit[k];
                lo_digit     = digit[k-1];
                two_digits   = 1'b1;
            end
        end
        if (!found && digit[0] != 4'd0) begin
            n_count = CNT_W'(1);
        end
    end

    always_comb begin
        n_pre_brand = BRAND_INVALID;
        if (two_digits) begin
            priority if (hi_digit == 4'd3 && (lo_digit == 4'd4 || lo_digit == 4'd7)) begin
                n_pre_brand = BRAND_P3X;
            end else if (hi_digit == 4'd5 && lo_digit >= 4'd1 && lo_digit <= 4'd5) begin
                n_pre_brand = BRAND_P5X;
            end else if (hi_digit == 4'd4) begin
                n_pre_brand = BRAND_P4X;
            end else begin
                n_pre_brand = BRAND_INVALID;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS_N; g++) begin
            n_psum[g] = '0;
            for (int j = 0; j < GROUP_SZ; j++) begin
                if (g * GROUP_SZ + j < DIGITS_N) begin
                    n_psum[g] = n_psum[g] + PSUM_W'(contrib[g * GROUP_SZ + j]);
                end
            end
        end
    end

    always_comb begin
        n_info.count     = n_count;
        n_info.pre_brand = n_pre_brand;
        n_info.psum      = n_psum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_info <= n_info;
        end
    end

    assign o_valid = r_valid;
    assign o_info  = r_info;

endmodule

FILE: src/cnl_verdict_stage.sv
module cnl_verdict_stage
    import cnl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_valid,
    input  t_digit_info      i_info,
    input  logic [CFG_W-1:0] i_min_digits,
    input  logic [CFG_W-1:0] i_max_digits,
    output logic             o_valid,
    output t_brand           o_brand,
    output logic [CNT_W-1:0] o_digit_count,
    output logic             o_luhn_ok
);

    logic             r_valid;
    t_brand           r_brand;
    logic [CNT_W-1:0] r_count;
    logic             r_luhn;

    t_brand           n_brand;
    logic             n_luhn;
    logic [SUM_W-1:0] sum;
    logic             len_ok;

    function automatic logic is_mult10(input logic [SUM_W-1:0] v);
        logic r;
        r = 1'b0;
        for (int m = 0; m <= SUM_MAX / 10; m++) begin
            if (v == SUM_W'(m * 10)) begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    always_comb begin
        sum = '0;
        for (int g = 0; g < GROUPS_N; g++) begin
            sum = sum + SUM_W'(i_info.psum[g]);
        end
        n_luhn = is_mult10(sum);
        len_ok = (i_info.count != '0)
              && (i_info.count <= CNT_W'(MAX_DIGITS))
              && (i_info.count >= i_min_digits)
              && (i_info.count <= i_max_digits);
        n_brand = (len_ok && n_luhn) ? i_info.pre_brand : BRAND_INVALID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_brand <= n_brand;
            r_count <= i_info.count;
            r_luhn  <= n_luhn;
        end
    end

    assign o_valid       = r_valid;
    assign o_brand       = r_brand;
    assign o_digit_count = r_count;
    assign o_luhn_ok     = r_luhn;

endmodule

FILE: src/card_number_luhn_classifier.sv
// Card number classifier with the Luhn mod-10 check.
//
// Input channel: i_valid / o_stall with i_card_number, a binary card number.
// A beat is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_brand, o_digit_count, o_luhn_ok,
// one result beat per input beat, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is min_digits, index 1 is max_digits, other indexes are ignored.
// Write it only while no beat is in flight.
//
// One beat enters per cycle while o_stall is low. Nine stages of six
// shift-and-add-3 steps each set the depth, then a digit stage (count,
// prefix, Luhn group sums) and a verdict stage that is also the output
// register.
// Reset (synchronous, active low) clears every valid bit and sets min_digits
// to 13 and max_digits to 16. While a result waits under i_stall, the whole
// pipeline holds and o_stall is raised; nothing is dropped or repeated.
module card_number_luhn_classifier
    import cnl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CARD_W-1:0]    i_card_number,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BRAND_W-1:0]   o_brand,
    output logic [CNT_W-1:0]     o_digit_count,
    output logic                 o_luhn_ok,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_min_digits;
    logic [CFG_W-1:0] r_max_digits;

    logic             advance;
    logic             conv_valid [CONV_STAGES+1];
    t_conv            conv_data  [CONV_STAGES+1];
    logic             dig_valid;
    t_digit_info      dig_info;
    t_brand           brand;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_digits <= MIN_DIGITS_RST;
            r_max_digits <= MAX_DIGITS_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MIN_DIGITS) begin
                r_min_digits <= i_cfg_data;
            end
            if (i_cfg_index == CFG_MAX_DIGITS) begin
                r_max_digits <= i_cfg_data;
            end
        end
    end

    // Hold every stage while a finished result is stalled at the output
    assign advance = !(o_valid && i_stall);
    assign o_stall = !advance;

    // Conversion starts with an empty decimal register
    assign conv_valid[0] = i_valid;
    assign conv_data[0]  = '{bcd: '0, bin: i_card_number};

    for (genvar s = 0; s < CONV_STAGES; s++) begin : g_conv
        cnl_bcd_stage u_bcd_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_valid   (conv_valid[s]),
            .i_data    (conv_data[s]),
            .o_valid   (conv_valid[s+1]),
            .o_data    (conv_data[s+1])
        );
    end

    cnl_digit_stage u_digit_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (conv_valid[CONV_STAGES]),
        .i_bcd     (conv_data[CONV_STAGES].bcd),
        .o_valid   (dig_valid),
        .o_info    (dig_info)
    );

    cnl_verdict_stage u_verdict_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_valid       (dig_valid),
        .i_info        (dig_info),
        .i_min_digits  (r_min_digits),
        .i_max_digits  (r_max_digits),
        .o_valid       (o_valid),
        .o_brand       (brand),
        .o_digit_count (o_digit_count),
        .o_luhn_ok     (o_luhn_ok)
    );

    assign o_brand = brand;

    // A branded result must have passed the Luhn check
    a_brand_needs_luhn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && brand != BRAND_INVALID) |-> o_luhn_ok)
        else $error("branded result without Luhn pass");

    // A branded result must lie in the length span
    a_brand_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && brand != BRAND_INVALID) |->
            (o_digit_count >= r_min_digits && o_digit_count <= r_max_digits
             && o_digit_count <= CNT_W'(MAX_DIGITS) && o_digit_count >= CNT_W'(2)))
        else $error("branded result outside length span");

    // Zero input gives no digits, a Luhn pass and no brand
    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_digit_count == '0) |-> (brand == BRAND_INVALID && o_luhn_ok))
        else $error("zero input misclassified");

    // Digit count never exceeds what 54 bits can hold
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_count <= CNT_W'(DIGITS_N)))
        else $error("digit count out of range");

endmodule
